### hdl/psue_pkg.sv
// ----------------------------------------------------------------------------
// psue_pkg
// Shared types and constants of the particle swarm update engine.
// ----------------------------------------------------------------------------
package psue_pkg;

  localparam int NUM_PARTICLES_DEF  = 32;
  localparam int NUM_DIMENSIONS_DEF = 16;

  // shared multiplier operand width and divider width
  localparam int MULW = 34;
  localparam int DIVW = 36;
  localparam int ACCW = 44;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_CLIP   = 2'd1,
    REQ_REPORT = 2'd2,
    REQ_UPDATE = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    REG_COG_GAIN   = 3'd0,
    REG_SOC_GAIN   = 3'd1,
    REG_VEL_LIMIT  = 3'd2,
    REG_INERTIA_HI = 3'd3,
    REG_INERTIA_LO = 3'd4,
    REG_ITER_COUNT = 3'd5,
    REG_BOUND_LOW  = 3'd6,
    REG_BOUND_HIGH = 3'd7
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_IDX,
    S_ADDR,
    S_RD,
    S_COPY,
    S_DS,
    S_DW,
    S_M2,
    S_M3,
    S_M4,
    S_M5,
    S_M6,
    S_M7,
    S_CL,
    S_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                   start;
    logic signed [DIVW-1:0] dividend;
    logic [15:0]            divisor;
  } div_req_t;

endpackage

### hdl/psue_if.sv
// ----------------------------------------------------------------------------
// psue_in_if / psue_out_if
// Item channels of the swarm engine: valid, ready and payload.
// ----------------------------------------------------------------------------
interface psue_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [4:0]         particle;
  logic [3:0]         dimension;
  logic signed [31:0] data_value;
  logic [15:0]        iteration;
  logic [15:0]        rand_one;
  logic [15:0]        rand_two;

  modport source (output valid, req_type, particle, dimension, data_value,
                  iteration, rand_one, rand_two, input ready);
  modport sink (input valid, req_type, particle, dimension, data_value,
                iteration, rand_one, rand_two, output ready);
endinterface

interface psue_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position_out;
  logic signed [31:0] global_best_score;
  logic signed [31:0] global_best_element;
  logic               personal_improved;
  logic               global_improved;

  modport source (output valid, position_out, global_best_score,
                  global_best_element, personal_improved, global_improved,
                  input ready);
  modport sink (input valid, position_out, global_best_score,
                global_best_element, personal_improved, global_improved,
                output ready);
endinterface

### hdl/particle_swarm_update_engine.sv
// ----------------------------------------------------------------------------
// particle_swarm_update_engine
// Linear-inertia particle swarm store and element update, Q16.16.
// ----------------------------------------------------------------------------
// One item is in flight at a time; a finished result waits in the output
// register while the next item is taken. A fitness report that improves a
// best copies the particle's position row into the improved bests, one
// element a cycle through the position memory read port once it is primed,
// and an element update runs the 36-step inertia divider and six passes
// through the one shared multiplier. A result held by the receiver adds its
// wait. After reset a clearing pass over all NUM_PARTICLES*NUM_DIMENSIONS
// cells zeroes velocities and best positions and sets best scores to S32_MAX
// before the first item is taken; configuration writes are accepted
// throughout.
// ----------------------------------------------------------------------------
module particle_swarm_update_engine import psue_pkg::*; #(
  parameter int NUM_PARTICLES  = NUM_PARTICLES_DEF,
  parameter int NUM_DIMENSIONS = NUM_DIMENSIONS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  psue_in_if.sink     req,
  psue_out_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CELLS = NUM_PARTICLES * NUM_DIMENSIONS;
  localparam int CAW   = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int PW    = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;
  localparam int DW    = (NUM_DIMENSIONS > 1) ? $clog2(NUM_DIMENSIONS) : 1;
  localparam int CNW   = $clog2(CELLS + 1);

  // configuration
  logic [22:0]        cog_gain;
  logic [22:0]        soc_gain;
  logic [30:0]        vel_limit;
  logic [17:0]        inertia_hi;
  logic [17:0]        inertia_lo;
  logic [15:0]        iter_count;
  logic signed [31:0] bound_low;
  logic signed [31:0] bound_high;

  state_t state, state_next;

  // latched item
  req_kind_t          rtype;
  logic [4:0]         pr;
  logic [3:0]         dr;
  logic signed [31:0] dval;
  logic [15:0]        iter;
  logic [15:0]        r1;
  logic [15:0]        r2;

  logic [CNW-1:0]     cnt;
  logic signed [31:0] x;
  logic signed [31:0] v;
  logic signed [31:0] pb;
  logic signed [31:0] gbe;
  logic signed [18:0] wreg;
  logic signed [ACCW-1:0] acc;
  logic signed [31:0] vclamp;
  logic signed [31:0] gbv;

  logic signed [31:0] r_pos;
  logic signed [31:0] r_gbe;
  logic               r_pimp;
  logic               r_gimp;

  logic [PW-1:0]      pidx;
  logic [DW-1:0]      didx;
  logic [CAW-1:0]     caddr;
  logic [CAW-1:0]     base;

  // memory ports
  logic           pos_we, vel_we, pbp_we, pbs_we, gb_we;
  logic [CAW-1:0] pos_waddr, pos_raddr, vel_waddr, pbp_waddr;
  logic [PW-1:0]  pbs_waddr;
  logic [DW-1:0]  gb_waddr;
  logic [31:0]    pos_wdata, vel_wdata, pbp_wdata, pbs_wdata, gb_wdata;
  logic [31:0]    pos_q, vel_q, pbp_q, pbs_q, gb_q;

  // arithmetic
  logic signed [MULW-1:0]   mul_a, mul_b;
  logic signed [2*MULW-1:0] mp;
  div_req_t                 dreq;
  logic                     div_done;
  logic signed [DIVW-1:0]   div_q;

  logic [15:0]        n_eff;
  logic [15:0]        it_eff;
  logic signed [18:0] idiff;
  logic signed [31:0] xl, xc;
  logic               pimp, gimp;
  logic signed [ACCW-1:0] vmax;
  logic signed [32:0] xsum;
  logic signed [31:0] xnew;

  assign pidx  = PW'(pr);
  assign didx  = DW'(dr);
  assign base  = CAW'(32'(pidx) * NUM_DIMENSIONS);
  assign caddr = CAW'(32'(pidx) * NUM_DIMENSIONS + 32'(didx));

  assign n_eff  = (iter_count == 16'd0) ? 16'd1 : iter_count;
  assign it_eff = (iter > n_eff) ? n_eff : iter;
  assign idiff  = $signed({1'b0, inertia_hi}) - $signed({1'b0, inertia_lo});

  assign xl   = ($signed(pos_q) < bound_low) ? bound_low : $signed(pos_q);
  assign xc   = (xl > bound_high) ? bound_high : xl;
  assign pimp = dval < $signed(pbs_q);
  assign gimp = dval < gbv;

  assign vmax = $signed({{(ACCW-31){1'b0}}, vel_limit});
  assign xsum = 33'(x) + 33'(vclamp);
  assign xnew = (xsum[32] != xsum[31]) ? (xsum[32] ? S32_MIN : S32_MAX) : xsum[31:0];

  assign req.ready = (state == S_IDLE);
  assign pready    = 1'b1;

  psue_ram #(.DEPTH(CELLS), .WIDTH(32)) u_pos (
    .clk, .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
    .raddr(pos_raddr), .rdata(pos_q)
  );
  psue_ram #(.DEPTH(CELLS), .WIDTH(32)) u_vel (
    .clk, .we(vel_we), .waddr(vel_waddr), .wdata(vel_wdata),
    .raddr(caddr), .rdata(vel_q)
  );
  psue_ram #(.DEPTH(CELLS), .WIDTH(32)) u_pbp (
    .clk, .we(pbp_we), .waddr(pbp_waddr), .wdata(pbp_wdata),
    .raddr(caddr), .rdata(pbp_q)
  );
  psue_ram #(.DEPTH(NUM_PARTICLES), .WIDTH(32)) u_pbs (
    .clk, .we(pbs_we), .waddr(pbs_waddr), .wdata(pbs_wdata),
    .raddr(pidx), .rdata(pbs_q)
  );
  psue_ram #(.DEPTH(NUM_DIMENSIONS), .WIDTH(32)) u_gb (
    .clk, .we(gb_we), .waddr(gb_waddr), .wdata(gb_wdata),
    .raddr(didx), .rdata(gb_q)
  );

  psue_alu u_alu (.clk, .a(mul_a), .b(mul_b), .p(mp));

  psue_div u_div (.clk, .rst, .req(dreq), .done(div_done), .quotient(div_q));

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      cog_gain   <= 23'd131072;
      soc_gain   <= 23'd131072;
      vel_limit  <= 31'd262144;
      inertia_hi <= 18'd58982;
      inertia_lo <= 18'd26214;
      iter_count <= 16'd100;
      bound_low  <= S32_MIN;
      bound_high <= S32_MAX;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx_t'(paddr[4:2]))
        REG_COG_GAIN:   cog_gain   <= pwdata[22:0];
        REG_SOC_GAIN:   soc_gain   <= pwdata[22:0];
        REG_VEL_LIMIT:  vel_limit  <= pwdata[30:0];
        REG_INERTIA_HI: inertia_hi <= pwdata[17:0];
        REG_INERTIA_LO: inertia_lo <= pwdata[17:0];
        REG_ITER_COUNT: iter_count <= pwdata[15:0];
        REG_BOUND_LOW:  bound_low  <= $signed(pwdata);
        REG_BOUND_HIGH: bound_high <= $signed(pwdata);
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[4:2]))
      REG_COG_GAIN:   prdata = 32'(cog_gain);
      REG_SOC_GAIN:   prdata = 32'(soc_gain);
      REG_VEL_LIMIT:  prdata = 32'(vel_limit);
      REG_INERTIA_HI: prdata = 32'(inertia_hi);
      REG_INERTIA_LO: prdata = 32'(inertia_lo);
      REG_ITER_COUNT: prdata = 32'(iter_count);
      REG_BOUND_LOW:  prdata = bound_low;
      REG_BOUND_HIGH: prdata = bound_high;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    pos_we        = 1'b0;
    pos_waddr     = caddr;
    pos_wdata     = dval;
    pos_raddr     = caddr;
    vel_we        = 1'b0;
    vel_waddr     = caddr;
    vel_wdata     = '0;
    pbp_we        = 1'b0;
    pbp_waddr     = caddr;
    pbp_wdata     = pos_q;
    pbs_we        = 1'b0;
    pbs_waddr     = pidx;
    pbs_wdata     = dval;
    gb_we         = 1'b0;
    gb_waddr      = didx;
    gb_wdata      = pos_q;
    mul_a         = '0;
    mul_b         = '0;
    dreq.start    = 1'b0;
    dreq.dividend = DIVW'(mp);
    dreq.divisor  = n_eff;
    unique case (state)
      S_CLEAR: begin
        vel_we    = 1'b1;
        vel_waddr = cnt[CAW-1:0];
        pbp_we    = 1'b1;
        pbp_waddr = cnt[CAW-1:0];
        pbp_wdata = '0;
        pbs_we    = 32'(cnt) < NUM_PARTICLES;
        pbs_waddr = cnt[PW-1:0];
        pbs_wdata = S32_MAX;
        gb_we     = 32'(cnt) < NUM_DIMENSIONS;
        gb_waddr  = cnt[DW-1:0];
        gb_wdata  = '0;
        if (cnt == CNW'(CELLS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_IDX;
        end
      end
      S_IDX: begin
        if (32'(pr) < NUM_PARTICLES && 32'(dr) < NUM_DIMENSIONS) begin
          state_next = S_ADDR;
        end
      end
      S_ADDR: state_next = S_RD;
      S_RD: begin
        unique case (rtype)
          REQ_LOAD: begin
            pos_we     = 1'b1;
            vel_we     = 1'b1;
            state_next = S_DONE;
          end
          REQ_CLIP: begin
            pos_we     = 1'b1;
            pos_wdata  = xc;
            state_next = S_DONE;
          end
          REQ_REPORT: begin
            pbs_we     = pimp;
            state_next = (pimp || gimp) ? S_COPY : S_DONE;
          end
          REQ_UPDATE: begin
            mul_a      = $signed({18'd0, it_eff});
            mul_b      = MULW'(idiff);
            state_next = S_DS;
          end
        endcase
      end
      S_COPY: begin
        pos_raddr = base + CAW'(cnt);
        if (cnt != '0) begin
          pbp_we    = r_pimp;
          pbp_waddr = base + CAW'(cnt - 1'b1);
          gb_we     = r_gimp;
          gb_waddr  = DW'(cnt - 1'b1);
        end
        if (cnt == CNW'(NUM_DIMENSIONS)) begin
          state_next = S_DONE;
        end
      end
      S_DS: begin
        dreq.start = 1'b1;
        state_next = S_DW;
      end
      S_DW: begin
        if (div_done) begin
          state_next = S_M2;
        end
      end
      S_M2: begin
        mul_a      = MULW'(wreg);
        mul_b      = MULW'(v);
        state_next = S_M3;
      end
      S_M3: begin
        mul_a      = $signed({11'd0, cog_gain});
        mul_b      = $signed({18'd0, r1});
        state_next = S_M4;
      end
      S_M4: begin
        mul_a      = $signed(mp[MULW+15:16]);
        mul_b      = MULW'(pb) - MULW'(x);
        state_next = S_M5;
      end
      S_M5: begin
        mul_a      = $signed({11'd0, soc_gain});
        mul_b      = $signed({18'd0, r2});
        state_next = S_M6;
      end
      S_M6: begin
        mul_a      = $signed(mp[MULW+15:16]);
        mul_b      = MULW'(gbe) - MULW'(x);
        state_next = S_M7;
      end
      S_M7: state_next = S_CL;
      S_CL: state_next = S_WR;
      S_WR: begin
        pos_we     = 1'b1;
        pos_wdata  = xnew;
        vel_we     = 1'b1;
        vel_wdata  = vclamp;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      gbv       <= S32_MAX;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: cnt <= cnt + 1'b1;
        S_IDLE: begin
          if (req.valid) begin
            rtype <= req_kind_t'(req.req_type);
            pr    <= req.particle;
            dr    <= req.dimension;
            dval  <= req.data_value;
            iter  <= req.iteration;
            r1    <= req.rand_one;
            r2    <= req.rand_two;
          end
        end
        S_IDX: begin
          if (32'(pr) >= NUM_PARTICLES) begin
            pr <= pr - 5'(NUM_PARTICLES);
          end
          if (32'(dr) >= NUM_DIMENSIONS) begin
            dr <= dr - 4'(NUM_DIMENSIONS);
          end
        end
        S_RD: begin
          cnt    <= '0;
          x      <= $signed(pos_q);
          v      <= $signed(vel_q);
          pb     <= $signed(pbp_q);
          gbe    <= $signed(gb_q);
          r_pimp <= (rtype == REQ_REPORT) && pimp;
          r_gimp <= (rtype == REQ_REPORT) && gimp;
          r_gbe  <= ((rtype == REQ_REPORT) && gimp) ? $signed(pos_q) : $signed(gb_q);
          unique case (rtype)
            REQ_LOAD:   r_pos <= dval;
            REQ_CLIP:   r_pos <= xc;
            REQ_REPORT: r_pos <= $signed(pos_q);
            REQ_UPDATE: r_pos <= $signed(pos_q);
          endcase
          if (rtype == REQ_REPORT && gimp) begin
            gbv <= dval;
          end
        end
        S_COPY: cnt <= cnt + 1'b1;
        S_DW: begin
          if (div_done) begin
            wreg <= 19'($signed({18'd0, inertia_hi}) - div_q);
          end
        end
        S_M3: acc <= ACCW'(mp >>> 16);
        S_M5: acc <= acc + ACCW'(mp >>> 16);
        S_M7: acc <= acc + ACCW'(mp >>> 16);
        S_CL: begin
          if (acc > vmax) begin
            vclamp <= 32'(vmax);
          end else if (acc < -vmax) begin
            vclamp <= 32'(-vmax);
          end else begin
            vclamp <= 32'(acc);
          end
        end
        S_WR: r_pos <= xnew;
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid               <= 1'b1;
            rsp.position_out        <= r_pos;
            rsp.global_best_score   <= gbv;
            rsp.global_best_element <= r_gbe;
            rsp.personal_improved   <= r_pimp;
            rsp.global_improved     <= r_gimp;
          end
        end
        default: ;
      endcase
    end
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("second item taken while one is in flight");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DW)
    else $error("divider finished outside its wait state");

  a_gbv_falls: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> gbv <= $past(gbv))
    else $error("global best score went up");

endmodule

### hdl/psue_ram.sv
// ----------------------------------------------------------------------------
// psue_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module psue_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hdl/psue_alu.sv
// ----------------------------------------------------------------------------
// psue_alu
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module psue_alu import psue_pkg::*; (
  input  logic                     clk,
  input  logic signed [MULW-1:0]   a,
  input  logic signed [MULW-1:0]   b,
  output logic signed [2*MULW-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

### hdl/psue_div.sv
// ----------------------------------------------------------------------------
// psue_div
// Restoring signed divider, one quotient bit a cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module psue_div import psue_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  div_req_t               req,
  output logic                   done,
  output logic signed [DIVW-1:0] quotient
);

  localparam int CW = $clog2(DIVW);

  logic            busy;
  logic [CW-1:0]   cnt;
  logic            neg;
  logic [16:0]     rem;
  logic [DIVW-1:0] quo;
  logic [16:0]     trial;
  logic            fits;

  assign trial = {rem[15:0], quo[DIVW-1]};
  assign fits  = trial >= {1'b0, req.divisor};
  assign quotient = neg ? -$signed(quo) : $signed(quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= req.dividend[DIVW-1];
        rem  <= '0;
        quo  <= req.dividend[DIVW-1] ? DIVW'(-req.dividend) : DIVW'(req.dividend);
      end else if (busy) begin
        rem <= fits ? (trial - {1'b0, req.divisor}) : trial;
        quo <= {quo[DIVW-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIVW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### dv/tb_particle_swarm_update_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_particle_swarm_update_engine
// Drives load, clip-read, fitness-report and element-update items into the
// swarm engine, runs through several register settings over APB and checks
// every result field against a cycle-free predictor of the swarm state.
// ----------------------------------------------------------------------------
module tb_particle_swarm_update_engine;
  import psue_pkg::*;

  localparam int NP = 32;
  localparam int ND = 16;
  localparam int CELLS = NP * ND;
  localparam int STALL_LIMIT = 6000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    req_kind_t          kind;
    logic [4:0]         particle;
    logic [3:0]         dimension;
    logic signed [31:0] data;
    logic [15:0]        iteration;
    logic [15:0]        r1;
    logic [15:0]        r2;
  } swarm_req_t;

  typedef struct {
    logic signed [31:0] pos;
    logic signed [31:0] gb_score;
    logic signed [31:0] gb_elem;
    logic               p_imp;
    logic               g_imp;
  } swarm_rsp_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  psue_in_if  req_ch();
  psue_out_if rsp_ch();

  particle_swarm_update_engine i_dut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  longint cog_gain, soc_gain, vel_lim, w_start, w_end, iter_cnt, lo_bound, hi_bound;
  int pos_mem[CELLS];
  int vel_mem[CELLS];
  int pbest_pos[CELLS];
  int pscore_mem[NP];
  int gbest_pos[ND];
  int gbest_score;

  // stimulus-side view of which positions were loaded
  bit loaded[CELLS];

  swarm_req_t pending_items[$];
  swarm_rsp_t expected_rsp[$];
  int mismatches = 0;
  bit burst_mode = 1'b0;
  bit hold_kick = 1'b0;
  int hold_cnt;
  int send_gap, recv_gap;
  int quiet_cycles;

  function automatic swarm_rsp_t swarm_step(swarm_req_t r);
    swarm_rsp_t o;
    int cidx, base;
    longint n, it, diff, w, x, k1, k2, v;
    cidx = int'(r.particle) * ND + int'(r.dimension);
    base = int'(r.particle) * ND;
    o.p_imp = 1'b0;
    o.g_imp = 1'b0;
    case (r.kind)
      REQ_LOAD: begin
        pos_mem[cidx] = r.data;
        vel_mem[cidx] = 0;
      end
      REQ_CLIP: begin
        x = longint'(pos_mem[cidx]);
        if (x < lo_bound) x = lo_bound;
        if (x > hi_bound) x = hi_bound;
        pos_mem[cidx] = int'(x);
      end
      REQ_REPORT: begin
        if (r.data < pscore_mem[r.particle]) begin
          pscore_mem[r.particle] = r.data;
          for (int i = 0; i < ND; i++) pbest_pos[base + i] = pos_mem[base + i];
          o.p_imp = 1'b1;
        end
        if (r.data < gbest_score) begin
          gbest_score = r.data;
          for (int i = 0; i < ND; i++) gbest_pos[i] = pos_mem[base + i];
          o.g_imp = 1'b1;
        end
      end
      default: begin
        n = (iter_cnt == 0) ? 1 : iter_cnt;
        it = longint'(r.iteration);
        if (it > n) it = n;
        diff = w_start - w_end;
        w = w_start - (it * diff) / n;
        x = longint'(pos_mem[cidx]);
        k1 = (cog_gain * longint'(r.r1)) >>> 16;
        k2 = (soc_gain * longint'(r.r2)) >>> 16;
        v = ((w * longint'(vel_mem[cidx])) >>> 16)
          + ((k1 * (longint'(pbest_pos[cidx]) - x)) >>> 16)
          + ((k2 * (longint'(gbest_pos[r.dimension]) - x)) >>> 16);
        if (v > vel_lim) v = vel_lim;
        if (v < -vel_lim) v = -vel_lim;
        vel_mem[cidx] = int'(v);
        x = x + v;
        if (x > 64'sd2147483647) x = 64'sd2147483647;
        if (x < -64'sd2147483648) x = -64'sd2147483648;
        pos_mem[cidx] = int'(x);
      end
    endcase
    o.pos = pos_mem[cidx];
    o.gb_score = gbest_score;
    o.gb_elem = gbest_pos[r.dimension];
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    swarm_req_t it;
    bit busy;
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.req_type <= REQ_LOAD;
      req_ch.particle <= '0;
      req_ch.dimension <= '0;
      req_ch.data_value <= '0;
      req_ch.iteration <= '0;
      req_ch.rand_one <= '0;
      req_ch.rand_two <= '0;
      send_gap <= 0;
    end else begin
      busy = req_ch.valid && !req_ch.ready;
      if (req_ch.valid && req_ch.ready) begin
        it.kind = req_kind_t'(req_ch.req_type);
        it.particle = req_ch.particle;
        it.dimension = req_ch.dimension;
        it.data = req_ch.data_value;
        it.iteration = req_ch.iteration;
        it.r1 = req_ch.rand_one;
        it.r2 = req_ch.rand_two;
        expected_rsp.push_back(swarm_step(it));
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.req_type <= it.kind;
          req_ch.particle <= it.particle;
          req_ch.dimension <= it.dimension;
          req_ch.data_value <= it.data;
          req_ch.iteration <= it.iteration;
          req_ch.rand_one <= it.r1;
          req_ch.rand_two <= it.r2;
          send_gap <= burst_mode ? 0 : $urandom_range(0, 10);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) hold_cnt <= 0;
    else if (hold_kick) hold_cnt <= 400;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
  end

  // monitor
  always @(posedge clk) begin
    swarm_rsp_t e;
    int w;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      w = recv_gap;
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item: pos %0d", rsp_ch.position_out);
        end else begin
          e = expected_rsp.pop_front();
          if (rsp_ch.position_out !== e.pos || rsp_ch.global_best_score !== e.gb_score ||
              rsp_ch.global_best_element !== e.gb_elem ||
              rsp_ch.personal_improved !== e.p_imp || rsp_ch.global_improved !== e.g_imp) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp pos %0d gbs %0d gbe %0d pi %0b gi %0b, got %0d %0d %0d %0b %0b",
                       e.pos, e.gb_score, e.gb_elem, e.p_imp, e.g_imp,
                       rsp_ch.position_out, rsp_ch.global_best_score,
                       rsp_ch.global_best_element, rsp_ch.personal_improved,
                       rsp_ch.global_improved);
          end
        end
        w = burst_mode ? 0 : $urandom_range(0, 10);
      end
      if (w > 0) begin
        recv_gap <= w - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        recv_gap <= 0;
        rsp_ch.ready <= (hold_cnt == 0);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (pending_items.size() == 0 && expected_rsp.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_particle_swarm_update_engine NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_COG_GAIN:   cog_gain = longint'(value & 32'h7fffff);
      REG_SOC_GAIN:   soc_gain = longint'(value & 32'h7fffff);
      REG_VEL_LIMIT:  vel_lim = longint'(value & 32'h7fffffff);
      REG_INERTIA_HI: w_start = longint'(value & 32'h3ffff);
      REG_INERTIA_LO: w_end = longint'(value & 32'h3ffff);
      REG_ITER_COUNT: iter_cnt = longint'(value & 32'hffff);
      REG_BOUND_LOW:  lo_bound = longint'($signed(value));
      default:        hi_bound = longint'($signed(value));
    endcase
  endtask

  task automatic set_all(logic [31:0] cg, logic [31:0] sg, logic [31:0] vl, logic [31:0] ws,
                         logic [31:0] we, logic [31:0] ic, logic [31:0] lb, logic [31:0] hb);
    reg_write(REG_COG_GAIN, cg);
    reg_write(REG_SOC_GAIN, sg);
    reg_write(REG_VEL_LIMIT, vl);
    reg_write(REG_INERTIA_HI, ws);
    reg_write(REG_INERTIA_LO, we);
    reg_write(REG_ITER_COUNT, ic);
    reg_write(REG_BOUND_LOW, lb);
    reg_write(REG_BOUND_HIGH, hb);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() > 0 || expected_rsp.size() > 0 || req_ch.valid);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_item(req_kind_t k, int p, int d, logic [31:0] data,
                           logic [15:0] iter, logic [15:0] r1, logic [15:0] r2);
    swarm_req_t it;
    it.kind = k;
    it.particle = 5'(p);
    it.dimension = 4'(d);
    it.data = data;
    it.iteration = iter;
    it.r1 = r1;
    it.r2 = r2;
    if (k == REQ_LOAD) loaded[p * ND + d] = 1'b1;
    pending_items.push_back(it);
  endtask

  function automatic logic [31:0] rand_position();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h7fffffff - $urandom_range(0, 3);
      2: return 32'h80000000 + $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_score();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'h7fffffff - $urandom_range(0, 1);
      default: return $signed($urandom_range(0, 20000)) - 32'sd10000;
    endcase
  endfunction

  // random items; anything that would touch an unloaded position becomes a load
  task automatic push_random(int count);
    int p, d, first_gap, pick;
    req_kind_t k;
    for (int n = 0; n < count; n++) begin
      p = $urandom_range(0, NP - 1);
      d = $urandom_range(0, ND - 1);
      pick = $urandom_range(0, 99);
      k = pick < 15 ? REQ_LOAD : pick < 30 ? REQ_CLIP : pick < 50 ? REQ_REPORT : REQ_UPDATE;
      first_gap = -1;
      for (int i = ND - 1; i >= 0; i--) if (!loaded[p * ND + i]) first_gap = i;
      if (k == REQ_REPORT && first_gap >= 0) begin
        k = REQ_LOAD;
        d = first_gap;
      end else if ((k == REQ_CLIP || k == REQ_UPDATE) && !loaded[p * ND + d]) begin
        k = REQ_LOAD;
      end
      push_item(k, p, d, k == REQ_REPORT ? rand_score() : rand_position(),
                16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                              : $urandom_range(0, 120)),
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    end
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cog_gain = 131072;
    soc_gain = 131072;
    vel_lim = 262144;
    w_start = 58982;
    w_end = 26214;
    iter_cnt = 100;
    lo_bound = -64'sd2147483648;
    hi_bound = 64'sd2147483647;
    for (int i = 0; i < CELLS; i++) begin
      pos_mem[i] = 0;
      vel_mem[i] = 0;
      pbest_pos[i] = 0;
      loaded[i] = 1'b0;
    end
    for (int i = 0; i < NP; i++) pscore_mem[i] = 32'h7fffffff;
    for (int i = 0; i < ND; i++) gbest_pos[i] = 0;
    gbest_score = 32'h7fffffff;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: fill particle 0, extremes, every operation
    for (int d = 0; d < ND; d++)
      push_item(REQ_LOAD, 0, d, d == 0 ? 32'h7fffffff : d == 15 ? 32'h80000000 : d << 16,
                0, 0, 0);
    push_item(REQ_CLIP, 0, 0, 0, 0, 0, 0);
    push_item(REQ_REPORT, 0, 3, 32'h7fffffff, 0, 0, 0);
    push_item(REQ_REPORT, 0, 3, 32'h80000000, 0, 0, 0);
    push_item(REQ_UPDATE, 0, 1, 0, 0, 16'hffff, 16'hffff);
    push_item(REQ_LOAD, 31, 15, 32'h7fffffff, 0, 0, 0);
    push_item(REQ_UPDATE, 31, 15, 0, 16'hffff, 16'hffff, 0);
    push_item(REQ_UPDATE, 0, 15, 0, 50, 0, 16'hffff);
    push_item(REQ_CLIP, 31, 15, 0, 0, 0, 0);
    push_random(300);
    wait_idle();

    // strongest gains, widest velocity, single-step schedule, tight bounds
    set_all(32'd4194304, 32'd4194304, 32'h7fffffff, 32'd131072, 32'd0, 32'd1,
            32'hff9c0000, 32'h00640000);
    push_random(330);
    wait_idle();

    // zero gains and velocity, zero iteration count, crossed bounds, long hold-off
    set_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd131072, 32'd0, 32'h00010000, 32'hffff0000);
    push_random(150);
    @(posedge clk);
    hold_kick <= 1'b1;
    @(posedge clk);
    hold_kick <= 1'b0;
    push_random(180);
    wait_idle();

    // random settings, no idling
    burst_mode = 1'b1;
    set_all($urandom_range(0, 4194304), $urandom_range(0, 4194304), $urandom_range(0, 32'h7fffffff),
            $urandom_range(0, 131072), $urandom_range(0, 131072), $urandom_range(1, 65535),
            32'h80000000 + $urandom_range(0, 32'h7fffffff), $urandom_range(0, 32'h7fffffff));
    push_random(330);
    wait_idle();
    burst_mode = 1'b0;

    for (int ph = 0; ph < 2; ph++) begin
      set_all($urandom_range(0, 4194304), $urandom_range(0, 4194304),
              $urandom_range(0, 32'h00100000), $urandom_range(0, 131072),
              $urandom_range(0, 131072), $urandom_range(1, 200),
              32'hff000000 + $urandom_range(0, 32'h00ffffff), $urandom_range(0, 32'h00ffffff));
      push_random(330);
      wait_idle();
    end

    if (mismatches == 0) $display("tb_particle_swarm_update_engine OK");
    else $display("tb_particle_swarm_update_engine NOT OK");
    $finish;
  end

endmodule

### filelist.f
hdl/psue_pkg.sv
hdl/psue_if.sv
hdl/psue_ram.sv
hdl/psue_alu.sv
hdl/psue_div.sv
hdl/particle_swarm_update_engine.sv
dv/tb_particle_swarm_update_engine.sv
